// ===== hw/rtl/stht_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the segment / triangle hit test
// no dependencies

package stht_pkg;

  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SEG_START_X = 3'd0;
  localparam cfg_idx_t REG_SEG_START_Y = 3'd1;
  localparam cfg_idx_t REG_SEG_START_Z = 3'd2;
  localparam cfg_idx_t REG_SEG_END_X   = 3'd3;
  localparam cfg_idx_t REG_SEG_END_Y   = 3'd4;
  localparam cfg_idx_t REG_SEG_END_Z   = 3'd5;

  typedef struct packed {
    logic crosses;
    logic coplanar;
  } plane_flags_t;

endpackage

// ===== hw/rtl/stht_cfg_regs.sv =====
`timescale 1ns / 1ps
// segment endpoint register file, written through the cfg_ channel
// depends on stht_pkg

module stht_cfg_regs #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  stht_pkg::cfg_idx_t            cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  output logic signed [COORD_WIDTH-1:0] seg_start [3],
  output logic signed [COORD_WIDTH-1:0] seg_end [3]
);
  import stht_pkg::*;

  logic signed [COORD_WIDTH-1:0] start_r [3];
  logic signed [COORD_WIDTH-1:0] end_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        start_r[k] <= '0;
        end_r[k]   <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEG_START_X: start_r[0] <= cfg_wdata;
        REG_SEG_START_Y: start_r[1] <= cfg_wdata;
        REG_SEG_START_Z: start_r[2] <= cfg_wdata;
        REG_SEG_END_X:   end_r[0]   <= cfg_wdata;
        REG_SEG_END_Y:   end_r[1]   <= cfg_wdata;
        REG_SEG_END_Z:   end_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign seg_start = start_r;
  assign seg_end   = end_r;

endmodule

// ===== hw/rtl/stht_plane.sv =====
`timescale 1ns / 1ps
// pipeline stages 1 to 3: vertex differences, plane distances of both
// segment endpoints and the per-edge normal cross products; no package use

module stht_plane #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       in_vld,
  input  logic signed [COORD_WIDTH-1:0]              vtx [3][3],
  input  logic signed [NORMAL_WIDTH-1:0]             nrm [3],
  input  logic signed [COORD_WIDTH-1:0]              seg_start [3],
  input  logic signed [COORD_WIDTH-1:0]              seg_end [3],
  output logic                                       out_vld,
  output logic signed [COORD_WIDTH+NORMAL_WIDTH+1:0] dist_start,
  output logic signed [COORD_WIDTH+NORMAL_WIDTH+1:0] dist_end,
  output logic signed [COORD_WIDTH+NORMAL_WIDTH:0]   edge_nrm [3][3],
  output logic signed [COORD_WIDTH:0]                rel_start [3][3],
  output logic signed [COORD_WIDTH:0]                rel_end [3][3]
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = DW + NORMAL_WIDTH;
  localparam int DDW = PW + 1;

  function automatic int nxt3(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  // stage 1
  logic signed [DW-1:0]           ed_nxt [3][3];
  logic signed [DW-1:0]           u_nxt [3][3];
  logic signed [DW-1:0]           w_nxt [3][3];
  logic signed [DW-1:0]           ed1_r [3][3];
  logic signed [DW-1:0]           u1_r [3][3];
  logic signed [DW-1:0]           w1_r [3][3];
  logic signed [NORMAL_WIDTH-1:0] nrm1_r [3];
  logic                           vld1_r;

  // stage 2
  logic signed [PW-1:0] pd1_r [3];
  logic signed [PW-1:0] pd2_r [3];
  logic signed [PW-1:0] mpa_r [3][3];
  logic signed [PW-1:0] mpb_r [3][3];
  logic signed [DW-1:0] u2_r [3][3];
  logic signed [DW-1:0] w2_r [3][3];
  logic                 vld2_r;

  // stage 3
  logic signed [DDW-1:0] d1_r;
  logic signed [DDW-1:0] d2_r;
  logic signed [PW-1:0]  m3_r [3][3];
  logic signed [DW-1:0]  u3_r [3][3];
  logic signed [DW-1:0]  w3_r [3][3];
  logic                  vld3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ed_nxt[i][k] = DW'(vtx[nxt3(i)][k]) - DW'(vtx[i][k]);
        u_nxt[i][k]  = DW'(seg_start[k]) - DW'(vtx[i][k]);
        w_nxt[i][k]  = DW'(seg_end[k]) - DW'(vtx[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ed1_r  <= ed_nxt;
      u1_r   <= u_nxt;
      w1_r   <= w_nxt;
      nrm1_r <= nrm;

      for (int k = 0; k < 3; k++) begin
        pd1_r[k] <= PW'(u1_r[0][k]) * PW'(nrm1_r[k]);
        pd2_r[k] <= PW'(w1_r[0][k]) * PW'(nrm1_r[k]);
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          mpa_r[i][k] <= PW'(nrm1_r[nxt3(k)]) * PW'(ed1_r[i][nxt3(nxt3(k))]);
          mpb_r[i][k] <= PW'(nrm1_r[nxt3(nxt3(k))]) * PW'(ed1_r[i][nxt3(k)]);
        end
      end
      u2_r <= u1_r;
      w2_r <= w1_r;

      d1_r <= DDW'(pd1_r[0]) + DDW'(pd1_r[1]) + DDW'(pd1_r[2]);
      d2_r <= DDW'(pd2_r[0]) + DDW'(pd2_r[1]) + DDW'(pd2_r[2]);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          m3_r[i][k] <= mpa_r[i][k] - mpb_r[i][k];
        end
      end
      u3_r <= u2_r;
      w3_r <= w2_r;
    end
  end

  assign out_vld    = vld3_r;
  assign dist_start = d1_r;
  assign dist_end   = d2_r;
  assign edge_nrm   = m3_r;
  assign rel_start  = u3_r;
  assign rel_end    = w3_r;

endmodule

// ===== hw/rtl/stht_edge.sv =====
`timescale 1ns / 1ps
// pipeline stages 4 and 5: crossing flags, distance magnitudes and the
// per-edge triple products for both endpoints; depends on stht_pkg

module stht_edge #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_vld,
  input  logic signed [COORD_WIDTH+NORMAL_WIDTH+1:0]   dist_start,
  input  logic signed [COORD_WIDTH+NORMAL_WIDTH+1:0]   dist_end,
  input  logic signed [COORD_WIDTH+NORMAL_WIDTH:0]     edge_nrm [3][3],
  input  logic signed [COORD_WIDTH:0]                  rel_start [3][3],
  input  logic signed [COORD_WIDTH:0]                  rel_end [3][3],
  output logic                                         out_vld,
  output stht_pkg::plane_flags_t                       flags,
  output logic [COORD_WIDTH+NORMAL_WIDTH:0]            mag_start,
  output logic [COORD_WIDTH+NORMAL_WIDTH:0]            mag_end,
  output logic signed [2*COORD_WIDTH+NORMAL_WIDTH+2:0] vol_start [3],
  output logic signed [2*COORD_WIDTH+NORMAL_WIDTH+2:0] vol_end [3]
);
  import stht_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = COORD_WIDTH + NORMAL_WIDTH + 1;
  localparam int DDW = MW + 1;
  localparam int AW  = MW;
  localparam int QW  = MW + DW;
  localparam int XW  = QW + 1;

  logic [DDW-1:0] neg_start;
  logic [DDW-1:0] neg_end;
  logic [AW-1:0]  mag_start_nxt;
  logic [AW-1:0]  mag_end_nxt;
  plane_flags_t   flags_nxt;

  // stage 4
  logic signed [QW-1:0] qs_r [3][3];
  logic signed [QW-1:0] qe_r [3][3];
  logic [AW-1:0]        mag_start4_r;
  logic [AW-1:0]        mag_end4_r;
  plane_flags_t         flags4_r;
  logic                 vld4_r;

  // stage 5
  logic signed [XW-1:0] vs5_r [3];
  logic signed [XW-1:0] ve5_r [3];
  logic [AW-1:0]        mag_start5_r;
  logic [AW-1:0]        mag_end5_r;
  plane_flags_t         flags5_r;
  logic                 vld5_r;

  always_comb begin
    neg_start          = -dist_start;
    neg_end            = -dist_end;
    mag_start_nxt      = dist_start[DDW-1] ? neg_start[AW-1:0] : dist_start[AW-1:0];
    mag_end_nxt        = dist_end[DDW-1] ? neg_end[AW-1:0] : dist_end[AW-1:0];
    flags_nxt.coplanar = (dist_start == '0) && (dist_end == '0);
    flags_nxt.crosses  = (dist_start == '0) || (dist_end == '0) ||
                         (dist_start[DDW-1] != dist_end[DDW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld4_r <= in_vld;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          qs_r[i][k] <= QW'(edge_nrm[i][k]) * QW'(rel_start[i][k]);
          qe_r[i][k] <= QW'(edge_nrm[i][k]) * QW'(rel_end[i][k]);
        end
      end
      mag_start4_r <= mag_start_nxt;
      mag_end4_r   <= mag_end_nxt;
      flags4_r     <= flags_nxt;

      for (int i = 0; i < 3; i++) begin
        vs5_r[i] <= XW'(qs_r[i][0]) + XW'(qs_r[i][1]) + XW'(qs_r[i][2]);
        ve5_r[i] <= XW'(qe_r[i][0]) + XW'(qe_r[i][1]) + XW'(qe_r[i][2]);
      end
      mag_start5_r <= mag_start4_r;
      mag_end5_r   <= mag_end4_r;
      flags5_r     <= flags4_r;
    end
  end

  assign out_vld   = vld5_r;
  assign flags     = flags5_r;
  assign mag_start = mag_start5_r;
  assign mag_end   = mag_end5_r;
  assign vol_start = vs5_r;
  assign vol_end   = ve5_r;

endmodule

// ===== hw/rtl/stht_sign.sv =====
`timescale 1ns / 1ps
// pipeline stages 6 to 8: limb-split wide products, their recombination
// and the final edge sign tests into the output register; depends on stht_pkg

module stht_sign #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_vld,
  input  stht_pkg::plane_flags_t                       flags,
  input  logic [COORD_WIDTH+NORMAL_WIDTH:0]            mag_start,
  input  logic [COORD_WIDTH+NORMAL_WIDTH:0]            mag_end,
  input  logic signed [2*COORD_WIDTH+NORMAL_WIDTH+2:0] vol_start [3],
  input  logic signed [2*COORD_WIDTH+NORMAL_WIDTH+2:0] vol_end [3],
  output logic                                         out_vld,
  output logic                                         out_crosses,
  output logic                                         out_hit
);
  import stht_pkg::*;

  localparam int AW        = COORD_WIDTH + NORMAL_WIDTH + 1;
  localparam int XW        = 2 * COORD_WIDTH + NORMAL_WIDTH + 3;
  localparam int NUM_LIMBS = 3;
  localparam int LW        = (XW + NUM_LIMBS - 1) / NUM_LIMBS;
  localparam int XEW       = NUM_LIMBS * LW;
  localparam int PPW       = AW + LW + 1;
  localparam int TW        = AW + XW + 1;

  logic signed [XEW-1:0] vs_ext [3];
  logic signed [XEW-1:0] ve_ext [3];
  logic signed [PPW-1:0] ps_nxt [3][NUM_LIMBS];
  logic signed [PPW-1:0] pe_nxt [3][NUM_LIMBS];
  logic signed [AW:0]    ms_sgn;
  logic signed [AW:0]    me_sgn;

  // stage 6
  logic signed [PPW-1:0] ps6_r [3][NUM_LIMBS];
  logic signed [PPW-1:0] pe6_r [3][NUM_LIMBS];
  plane_flags_t          flags6_r;
  logic                  vld6_r;

  // stage 7
  logic signed [TW-1:0] ts_nxt [3];
  logic signed [TW-1:0] te_nxt [3];
  logic signed [TW-1:0] ts7_r [3];
  logic signed [TW-1:0] te7_r [3];
  plane_flags_t         flags7_r;
  logic                 vld7_r;

  // stage 8, output register
  logic signed [TW-1:0] tot [3];
  logic [2:0]           edge_ok;
  logic                 hit_nxt;
  logic                 crosses_r;
  logic                 hit_r;
  logic                 vld8_r;

  // a unsigned magnitude times a signed volume, one limb of the volume each;
  // the top limb carries the sign
  always_comb begin
    ms_sgn = $signed({1'b0, mag_start});
    me_sgn = $signed({1'b0, mag_end});
    for (int i = 0; i < 3; i++) begin
      vs_ext[i] = XEW'(vol_start[i]);
      ve_ext[i] = XEW'(vol_end[i]);
      for (int j = 0; j < NUM_LIMBS; j++) begin
        if (j == NUM_LIMBS - 1) begin
          ps_nxt[i][j] = PPW'(me_sgn) * PPW'($signed(vs_ext[i][j*LW +: LW]));
          pe_nxt[i][j] = PPW'(ms_sgn) * PPW'($signed(ve_ext[i][j*LW +: LW]));
        end else begin
          ps_nxt[i][j] = PPW'(me_sgn) * PPW'($signed({1'b0, vs_ext[i][j*LW +: LW]}));
          pe_nxt[i][j] = PPW'(ms_sgn) * PPW'($signed({1'b0, ve_ext[i][j*LW +: LW]}));
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ts_nxt[i] = '0;
      te_nxt[i] = '0;
      for (int j = 0; j < NUM_LIMBS; j++) begin
        ts_nxt[i] = ts_nxt[i] + (TW'(ps6_r[i][j]) << (j * LW));
        te_nxt[i] = te_nxt[i] + (TW'(pe6_r[i][j]) << (j * LW));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i]     = ts7_r[i] + te7_r[i];
      edge_ok[i] = !tot[i][TW-1];
    end
    hit_nxt = flags7_r.crosses && (flags7_r.coplanar || (&edge_ok));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else if (en) begin
      vld6_r <= in_vld;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps6_r     <= ps_nxt;
      pe6_r     <= pe_nxt;
      flags6_r  <= flags;
      ts7_r     <= ts_nxt;
      te7_r     <= te_nxt;
      flags7_r  <= flags6_r;
      crosses_r <= flags7_r.crosses;
      hit_r     <= hit_nxt;
    end
  end

  assign out_vld     = vld8_r;
  assign out_crosses = crosses_r;
  assign out_hit     = hit_r;

endmodule

// ===== hw/rtl/segment_triangle_hit_test.sv =====
`timescale 1ns / 1ps
// segment / triangle hit test, top level
// depends on stht_pkg, stht_cfg_regs, stht_plane, stht_edge, stht_sign
//
// usage
//  - cfg_ channel: write the segment start and end coordinates, register
//    index 0..5 = start x, y, z, end x, y, z; indices 6 and 7 are ignored.
//    cfg_ready is always high; write only while the pipeline is empty
//  - in_ channel: one triangle (three vertices and a face normal) per
//    transaction, taken when in_valid is high and in_stall is low
//  - out_ channel: one result per triangle, in order: out_crosses_plane and
//    out_hit (hit includes the edges; a segment lying in the plane is a hit)
//  - eight register stages lie between the in_ channel and the out_ ports
//  - one triangle per cycle while not stalled; the rate is set by the
//    eight-stage multiplier pipeline, with the widest products split into limbs
//  - out_stall with out_valid high freezes the whole pipeline and raises
//    in_stall in the same cycle; nothing is dropped or repeated
//  - reset (rst_n low, synchronous) empties the pipeline and clears the
//    segment registers to zero

module segment_triangle_hit_test #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_wdata,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_a_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_b_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_c_z,
  input  logic signed [NORMAL_WIDTH-1:0] in_normal_x,
  input  logic signed [NORMAL_WIDTH-1:0] in_normal_y,
  input  logic signed [NORMAL_WIDTH-1:0] in_normal_z,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_crosses_plane,
  output logic                           out_hit
);
  import stht_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = COORD_WIDTH + NORMAL_WIDTH + 1;
  localparam int DDW = MW + 1;
  localparam int AW  = MW;
  localparam int XW  = 2 * COORD_WIDTH + NORMAL_WIDTH + 3;

  logic                           en;
  logic signed [COORD_WIDTH-1:0]  vtx [3][3];
  logic signed [NORMAL_WIDTH-1:0] nrm [3];
  logic signed [COORD_WIDTH-1:0]  seg_start [3];
  logic signed [COORD_WIDTH-1:0]  seg_end [3];

  logic                  plane_vld;
  logic signed [DDW-1:0] dist_start;
  logic signed [DDW-1:0] dist_end;
  logic signed [MW-1:0]  edge_nrm [3][3];
  logic signed [DW-1:0]  rel_start [3][3];
  logic signed [DW-1:0]  rel_end [3][3];

  logic                 edge_vld;
  plane_flags_t         flags;
  logic [AW-1:0]        mag_start;
  logic [AW-1:0]        mag_end;
  logic signed [XW-1:0] vol_start [3];
  logic signed [XW-1:0] vol_end [3];

  // the whole pipeline moves unless a finished result is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign vtx[0][0] = in_vertex_a_x;
  assign vtx[0][1] = in_vertex_a_y;
  assign vtx[0][2] = in_vertex_a_z;
  assign vtx[1][0] = in_vertex_b_x;
  assign vtx[1][1] = in_vertex_b_y;
  assign vtx[1][2] = in_vertex_b_z;
  assign vtx[2][0] = in_vertex_c_x;
  assign vtx[2][1] = in_vertex_c_y;
  assign vtx[2][2] = in_vertex_c_z;
  assign nrm[0]    = in_normal_x;
  assign nrm[1]    = in_normal_y;
  assign nrm[2]    = in_normal_z;

  stht_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .seg_start (seg_start),
    .seg_end   (seg_end)
  );

  stht_plane #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_plane (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_valid),
    .vtx        (vtx),
    .nrm        (nrm),
    .seg_start  (seg_start),
    .seg_end    (seg_end),
    .out_vld    (plane_vld),
    .dist_start (dist_start),
    .dist_end   (dist_end),
    .edge_nrm   (edge_nrm),
    .rel_start  (rel_start),
    .rel_end    (rel_end)
  );

  stht_edge #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (plane_vld),
    .dist_start (dist_start),
    .dist_end   (dist_end),
    .edge_nrm   (edge_nrm),
    .rel_start  (rel_start),
    .rel_end    (rel_end),
    .out_vld    (edge_vld),
    .flags      (flags),
    .mag_start  (mag_start),
    .mag_end    (mag_end),
    .vol_start  (vol_start),
    .vol_end    (vol_end)
  );

  stht_sign #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_sign (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (edge_vld),
    .flags       (flags),
    .mag_start   (mag_start),
    .mag_end     (mag_end),
    .vol_start   (vol_start),
    .vol_end     (vol_end),
    .out_vld     (out_valid),
    .out_crosses (out_crosses_plane),
    .out_hit     (out_hit)
  );

endmodule
